// ===== hdl/wsdf_pkg.sv =====
// shared constants for the websocket frame deframer
package wsdf_pkg;

    typedef logic [1:0] kind_t;
    typedef logic [3:0] opcode_t;

    localparam kind_t KIND_BYTE  = 2'd0;
    localparam kind_t KIND_EMPTY = 2'd1;
    localparam kind_t KIND_CLOSE = 2'd2;

    localparam opcode_t OP_TEXT   = 4'h1;
    localparam opcode_t OP_BINARY = 4'h2;
    localparam opcode_t OP_CLOSE  = 4'h8;
    localparam opcode_t OP_PING   = 4'h9;

    localparam logic [6:0] LEN7_EXT16 = 7'd126;
    localparam logic [6:0] LEN7_EXT64 = 7'd127;

    localparam logic [2:0] EXT16_LAST = 3'd1;
    localparam logic [2:0] EXT64_LAST = 3'd7;
    localparam logic [2:0] MASK_LAST  = 3'd3;

endpackage

// ===== hdl/websocket_frame_deframer.sv =====
// websocket frame deframer: parses a received byte stream into unmasked payload words
// Takes one stream byte per cycle and keeps that rate as long as the result side accepts
// words; a byte passes an input register, one pass over the header/payload parser state, and
// a result register, from which its result word is presented. A
// stalled result word holds back only a byte that would produce another word; header bytes
// and dropped payload bytes keep flowing. Text, binary and ping payload bytes come out
// unmasked with their opcode and a last flag; an empty data frame gives one empty-message
// word, a close frame gives one close word after its payload, and after that every byte is
// swallowed until reset. LENGTH_BITS (16 to 64) sets the length counter width; longer frame
// lengths saturate at its all-ones value. There is no clearing pass after reset.
module websocket_frame_deframer #(
    parameter int LENGTH_BITS = 64
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  rx_valid,
    output logic                  rx_stall,
    input  logic [7:0]            rx_byte,
    output logic                  res_valid,
    input  logic                  res_stall,
    output wsdf_pkg::kind_t       kind,
    output wsdf_pkg::opcode_t     frame_opcode,
    output logic [7:0]            data_byte,
    output logic                  last_of_message
);
    import wsdf_pkg::*;

    typedef enum logic [2:0] {
        PH_HDR0    = 3'd0,
        PH_HDR1    = 3'd1,
        PH_EXT16   = 3'd2,
        PH_EXT64   = 3'd3,
        PH_MASK    = 3'd4,
        PH_PAYLOAD = 3'd5,
        PH_CLOSED  = 3'd6
    } phase_t;

    localparam logic [LENGTH_BITS-1:0] LEN_ONE = LENGTH_BITS'(1);

    phase_t                 phase_reg, phase_next;
    opcode_t                op_reg, op_next;
    logic                   mask_reg, mask_next;
    logic [2:0]             cnt_reg, cnt_next;
    logic [LENGTH_BITS-1:0] rem_reg, rem_next;
    logic [31:0]            key_reg, key_next;
    logic [1:0]             idx_reg, idx_next;

    logic                   in_v_reg;
    logic [7:0]             byte_reg;

    logic                   out_v_reg;
    kind_t                  kind_reg;
    opcode_t                opc_reg;
    logic [7:0]             data_reg;
    logic                   last_reg;

    logic                   has_res;
    kind_t                  res_kind;
    opcode_t                res_op;
    logic [7:0]             res_data;
    logic                   res_last;
    logic                   fin_len;
    logic                   fin_hdr;
    logic                   is_data_op;
    logic [2:0]             need;
    logic [7:0]             key_byte;
    logic [LENGTH_BITS-1:0] rem_shift;
    logic                   advance;
    logic                   out_free;

    assign is_data_op = (op_reg == OP_TEXT) || (op_reg == OP_BINARY) || (op_reg == OP_PING);
    assign key_byte   = key_reg[{~idx_reg, 3'b000} +: 8];
    assign rem_shift  = (rem_reg[LENGTH_BITS-1 -: 8] != 8'd0) ? '1
                        : {rem_reg[LENGTH_BITS-9:0], byte_reg};

    always_comb
    begin
        phase_next = phase_reg;
        op_next    = op_reg;
        mask_next  = mask_reg;
        cnt_next   = cnt_reg;
        rem_next   = rem_reg;
        key_next   = key_reg;
        idx_next   = idx_reg;
        has_res    = 1'b0;
        res_kind   = KIND_BYTE;
        res_op     = op_reg;
        res_data   = 8'd0;
        res_last   = 1'b0;
        fin_len    = 1'b0;
        fin_hdr    = 1'b0;
        need       = EXT64_LAST;
        case (phase_reg)
            PH_HDR1:
            begin
                mask_next = byte_reg[7];
                cnt_next  = 3'd0;
                rem_next  = '0;
                if (byte_reg[6:0] == LEN7_EXT16)
                begin
                    phase_next = PH_EXT16;
                end
                else if (byte_reg[6:0] == LEN7_EXT64)
                begin
                    phase_next = PH_EXT64;
                end
                else
                begin
                    rem_next = {{(LENGTH_BITS-7){1'b0}}, byte_reg[6:0]};
                    fin_len  = 1'b1;
                end
            end
            PH_EXT16, PH_EXT64:
            begin
                need     = (phase_reg == PH_EXT16) ? EXT16_LAST : EXT64_LAST;
                rem_next = rem_shift;
                if (cnt_reg >= need)
                begin
                    fin_len = 1'b1;
                end
                else
                begin
                    cnt_next = cnt_reg + 3'd1;
                end
            end
            PH_MASK:
            begin
                key_next = {key_reg[23:0], byte_reg};
                if (cnt_reg >= MASK_LAST)
                begin
                    fin_hdr = 1'b1;
                end
                else
                begin
                    cnt_next = cnt_reg + 3'd1;
                end
            end
            PH_PAYLOAD:
            begin
                idx_next = idx_reg + 2'd1;
                rem_next = rem_reg - LEN_ONE;
                res_last = (rem_reg == LEN_ONE);
                if (res_last)
                begin
                    phase_next = (op_reg == OP_CLOSE) ? PH_CLOSED : PH_HDR0;
                end
                if (is_data_op)
                begin
                    has_res  = 1'b1;
                    res_kind = KIND_BYTE;
                    res_data = mask_reg ? (byte_reg ^ key_byte) : byte_reg;
                end
                else if (res_last && op_reg == OP_CLOSE)
                begin
                    has_res  = 1'b1;
                    res_kind = KIND_CLOSE;
                    res_op   = OP_CLOSE;
                end
            end
            PH_CLOSED:
            begin
                phase_next = PH_CLOSED;
            end
            default:
            begin
                op_next    = byte_reg[3:0];
                phase_next = PH_HDR1;
            end
        endcase

        // length complete: key or end of header
        if (fin_len)
        begin
            cnt_next = 3'd0;
            if (mask_next)
            begin
                phase_next = PH_MASK;
            end
            else
            begin
                fin_hdr = 1'b1;
            end
        end

        // header complete: payload or empty frame
        if (fin_hdr)
        begin
            cnt_next = 3'd0;
            idx_next = 2'd0;
            if (rem_next != '0)
            begin
                phase_next = PH_PAYLOAD;
            end
            else if (op_reg == OP_CLOSE)
            begin
                phase_next = PH_CLOSED;
                has_res    = 1'b1;
                res_kind   = KIND_CLOSE;
                res_op     = OP_CLOSE;
                res_last   = 1'b1;
            end
            else
            begin
                phase_next = PH_HDR0;
                if (is_data_op)
                begin
                    has_res  = 1'b1;
                    res_kind = KIND_EMPTY;
                    res_last = 1'b1;
                end
            end
        end
    end

    assign out_free = !out_v_reg || !res_stall;
    assign advance  = in_v_reg && (!has_res || out_free);
    assign rx_stall = in_v_reg && !advance;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_HDR0;
            op_reg    <= '0;
            mask_reg  <= 1'b0;
            cnt_reg   <= '0;
            rem_reg   <= '0;
            key_reg   <= '0;
            idx_reg   <= '0;
            in_v_reg  <= 1'b0;
            byte_reg  <= '0;
            out_v_reg <= 1'b0;
            kind_reg  <= KIND_BYTE;
            opc_reg   <= '0;
            data_reg  <= '0;
            last_reg  <= 1'b0;
        end
        else
        begin
            if (rx_valid && !rx_stall)
            begin
                in_v_reg <= 1'b1;
                byte_reg <= rx_byte;
            end
            else if (advance)
            begin
                in_v_reg <= 1'b0;
            end

            if (advance)
            begin
                phase_reg <= phase_next;
                op_reg    <= op_next;
                mask_reg  <= mask_next;
                cnt_reg   <= cnt_next;
                rem_reg   <= rem_next;
                key_reg   <= key_next;
                idx_reg   <= idx_next;
            end

            if (advance && has_res)
            begin
                out_v_reg <= 1'b1;
                kind_reg  <= res_kind;
                opc_reg   <= res_op;
                data_reg  <= res_data;
                last_reg  <= res_last;
            end
            else if (!res_stall)
            begin
                out_v_reg <= 1'b0;
            end
        end
    end

    assign res_valid       = out_v_reg;
    assign kind            = kind_reg;
    assign frame_opcode    = opc_reg;
    assign data_byte       = data_reg;
    assign last_of_message = last_reg;

`ifndef SYNTHESIS
    a_closed_silent: assert property (@(posedge clk) disable iff (!rst_n)
        (phase_reg == PH_CLOSED) |-> !(advance && has_res))
        else $error("result produced after close");

    a_result_lands: assert property (@(posedge clk) disable iff (!rst_n)
        (advance && has_res) |=> (res_valid && kind == $past(res_kind)))
        else $error("result word lost");

    a_flag_words_last: assert property (@(posedge clk) disable iff (!rst_n)
        (res_valid && kind != KIND_BYTE) |-> (last_of_message && data_byte == 8'd0))
        else $error("empty or close word malformed");

    a_close_enters_closed: assert property (@(posedge clk) disable iff (!rst_n)
        (advance && has_res && res_kind == KIND_CLOSE) |=> (phase_reg == PH_CLOSED))
        else $error("close word without closed state");
`endif

endmodule

// ===== tb/deframer_checker.sv =====
// checker for the websocket frame deframer: watches both channels, predicts and compares words
`timescale 1ns / 100ps
module deframer_checker #(
    parameter int LENGTH_BITS = 64
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              rx_valid,
    input  logic              rx_stall,
    input  logic [7:0]        rx_byte,
    input  logic              res_valid,
    input  logic              res_stall,
    input  wsdf_pkg::kind_t   kind,
    input  wsdf_pkg::opcode_t frame_opcode,
    input  logic [7:0]        data_byte,
    input  logic              last_of_message,
    output int                mismatches,
    output int                words_due
);
    import wsdf_pkg::*;

    localparam logic [63:0] LEN_MAX = {64{1'b1}} >> (64 - LENGTH_BITS);

    typedef enum logic [2:0] {
        PH_HDR0,
        PH_HDR1,
        PH_EXT16,
        PH_EXT64,
        PH_MASK,
        PH_PAYLOAD,
        PH_CLOSED
    } phase_t;

    typedef struct packed {
        kind_t      kind;
        opcode_t    opcode;
        logic [7:0] data;
        logic       last;
    } out_word_t;

    phase_t      phase;
    opcode_t     held_op;
    logic        masked;
    logic [2:0]  field_cnt;
    logic [63:0] remaining;
    logic [31:0] key;
    logic [1:0]  key_idx;
    out_word_t   pending_words[$];
    int          err_count = 0;

    function automatic bit carries_data(input opcode_t op);
        return op == OP_TEXT || op == OP_BINARY || op == OP_PING;
    endfunction

    task automatic expect_word(input kind_t k, input opcode_t op, input logic [7:0] d,
                               input logic l);
        out_word_t w;
        w.kind   = k;
        w.opcode = op;
        w.data   = d;
        w.last   = l;
        pending_words.push_back(w);
    endtask

    task automatic header_complete;
        field_cnt = '0;
        key_idx   = '0;
        if (remaining != 0)
            phase = PH_PAYLOAD;
        else if (held_op == OP_CLOSE)
        begin
            phase = PH_CLOSED;
            expect_word(KIND_CLOSE, OP_CLOSE, 8'h00, 1'b1);
        end
        else
        begin
            phase = PH_HDR0;
            if (carries_data(held_op))
                expect_word(KIND_EMPTY, held_op, 8'h00, 1'b1);
        end
    endtask

    task automatic length_complete;
        field_cnt = '0;
        if (masked)
            phase = PH_MASK;
        else
            header_complete();
    endtask

    task automatic parse_byte(input logic [7:0] b);
        logic [7:0] plain;
        logic [2:0] need;
        int         sh;
        case (phase)
            PH_HDR1:
            begin
                masked    = b[7];
                field_cnt = '0;
                remaining = '0;
                if (b[6:0] == LEN7_EXT16)
                    phase = PH_EXT16;
                else if (b[6:0] == LEN7_EXT64)
                    phase = PH_EXT64;
                else
                begin
                    remaining = 64'(b[6:0]);
                    length_complete();
                end
            end
            PH_EXT16, PH_EXT64:
            begin
                need = (phase == PH_EXT16) ? EXT16_LAST : EXT64_LAST;
                if (remaining > (LEN_MAX >> 8))
                    remaining = LEN_MAX;
                else
                    remaining = ((remaining << 8) | 64'(b)) & LEN_MAX;
                if (field_cnt >= need)
                    length_complete();
                else
                    field_cnt = field_cnt + 3'd1;
            end
            PH_MASK:
            begin
                key = {key[23:0], b};
                if (field_cnt >= MASK_LAST)
                    header_complete();
                else
                    field_cnt = field_cnt + 3'd1;
            end
            PH_PAYLOAD:
            begin
                // first key byte received sits in the top of the key register
                sh        = 24 - 8 * int'(key_idx);
                plain     = masked ? (b ^ 8'(key >> sh)) : b;
                key_idx   = key_idx + 2'd1;
                remaining = (remaining - 64'd1) & LEN_MAX;
                if (remaining == 0)
                    phase = (held_op == OP_CLOSE) ? PH_CLOSED : PH_HDR0;
                if (carries_data(held_op))
                    expect_word(KIND_BYTE, held_op, plain, remaining == 0);
                else if (remaining == 0 && held_op == OP_CLOSE)
                    expect_word(KIND_CLOSE, OP_CLOSE, 8'h00, 1'b1);
            end
            PH_CLOSED:
            begin
            end
            default:
            begin
                held_op = b[3:0];
                phase   = PH_HDR1;
            end
        endcase
    endtask

    task automatic compare_field(input string name, input logic [7:0] want,
                                 input logic [7:0] got);
        if (got !== want)
        begin
            err_count++;
            $display("%0t: %s mismatch, expected %0h, got %0h", $time, name, want, got);
        end
    endtask

    task automatic check_word;
        out_word_t want;
        if (pending_words.size() == 0)
        begin
            err_count++;
            $display("%0t: unexpected word, expected none, got kind %0d op %0h data %0h last %0b",
                     $time, kind, frame_opcode, data_byte, last_of_message);
        end
        else
        begin
            want = pending_words.pop_front();
            compare_field("kind", 8'(want.kind), 8'(kind));
            compare_field("frame_opcode", 8'(want.opcode), 8'(frame_opcode));
            compare_field("data_byte", want.data, data_byte);
            compare_field("last_of_message", 8'(want.last), 8'(last_of_message));
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase     = PH_HDR0;
            held_op   = '0;
            masked    = 1'b0;
            field_cnt = '0;
            remaining = '0;
            key       = '0;
            key_idx   = '0;
            pending_words.delete();
            words_due <= 0;
        end
        else
        begin
            // the word leaving now was caused by an earlier byte
            if (res_valid && !res_stall)
                check_word();
            if (rx_valid && !rx_stall)
                parse_byte(rx_byte);
            words_due  <= pending_words.size();
            mismatches <= err_count;
        end
    end

endmodule

// ===== tb/tb_websocket_frame_deframer.sv =====
// testbench top for the websocket frame deframer: stream stimulus, idling and verdict
`timescale 1ns / 100ps
module tb_websocket_frame_deframer;
    import wsdf_pkg::*;

    localparam int LENGTH_BITS  = 64;
    localparam int IDLE_LIMIT   = 2000;
    localparam int STREAM_BYTES = 600;
    localparam int DRAIN_CYCLES = 16;

    localparam opcode_t OP_PONG     = 4'hA;
    localparam opcode_t OP_RESERVED = 4'hF;

    typedef enum {LEN_SHORT, LEN_EXT16, LEN_EXT64} len_form_t;

    logic       clk;
    logic       rst_n;
    logic       rx_valid;
    logic       rx_stall;
    logic [7:0] rx_byte;
    logic       res_valid;
    logic       res_stall;
    kind_t      kind;
    opcode_t    frame_opcode;
    logic [7:0] data_byte;
    logic       last_of_message;
    int         mismatches;
    int         words_due;
    int         bytes_sent = 0;
    int         calm_left = 0;

    websocket_frame_deframer #(
        .LENGTH_BITS(LENGTH_BITS)
    ) u_top (
        .clk(clk),
        .rst_n(rst_n),
        .rx_valid(rx_valid),
        .rx_stall(rx_stall),
        .rx_byte(rx_byte),
        .res_valid(res_valid),
        .res_stall(res_stall),
        .kind(kind),
        .frame_opcode(frame_opcode),
        .data_byte(data_byte),
        .last_of_message(last_of_message)
    );

    deframer_checker #(
        .LENGTH_BITS(LENGTH_BITS)
    ) u_checker (
        .clk(clk),
        .rst_n(rst_n),
        .rx_valid(rx_valid),
        .rx_stall(rx_stall),
        .rx_byte(rx_byte),
        .res_valid(res_valid),
        .res_stall(res_stall),
        .kind(kind),
        .frame_opcode(frame_opcode),
        .data_byte(data_byte),
        .last_of_message(last_of_message),
        .mismatches(mismatches),
        .words_due(words_due)
    );

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    function automatic int idle_span();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        if (r < 88)
            return $urandom_range(1, 3);
        if (r < 97)
            return $urandom_range(4, 12);
        return $urandom_range(13, 40);
    endfunction

    task automatic push_stream_byte(input logic [7:0] b);
        int gap;
        if (calm_left > 0)
        begin
            calm_left--;
            gap = 0;
        end
        else
        begin
            gap = idle_span();
            if ($urandom_range(0, 99) < 4)
                calm_left = $urandom_range(40, 120);
        end
        if (gap > 0)
        begin
            rx_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        rx_valid <= 1'b1;
        rx_byte  <= b;
        @(posedge clk);
        while (rx_stall)
            @(posedge clk);
        @(negedge clk);
        bytes_sent++;
    endtask

    task automatic send_frame(input logic [3:0] flags, input opcode_t op, input bit with_mask,
                              input int len, input len_form_t form);
        logic [63:0] len_field;
        int          i;
        len_field = 64'(len);
        push_stream_byte({flags, op});
        case (form)
            LEN_SHORT:
                push_stream_byte({with_mask, 7'(len)});
            LEN_EXT16:
            begin
                push_stream_byte({with_mask, LEN7_EXT16});
                push_stream_byte(len_field[15:8]);
                push_stream_byte(len_field[7:0]);
            end
            default:
            begin
                push_stream_byte({with_mask, LEN7_EXT64});
                for (i = 7; i >= 0; i--)
                    push_stream_byte(len_field[8*i +: 8]);
            end
        endcase
        if (with_mask)
            repeat (4) push_stream_byte(8'($urandom));
        repeat (len) push_stream_byte(8'($urandom));
    endtask

    task automatic send_random_frame;
        opcode_t op;
        int      r;
        if ($urandom_range(0, 99) < 80)
        begin
            r = $urandom_range(0, 2);
            op = (r == 0) ? OP_TEXT : (r == 1) ? OP_BINARY : OP_PING;
        end
        else
        begin
            // opcodes whose payload is dropped, close kept for the end of the stream
            op = 4'($urandom);
            while (op == OP_TEXT || op == OP_BINARY || op == OP_PING || op == OP_CLOSE)
                op = 4'($urandom);
        end
        r = $urandom_range(0, 99);
        if (r < 65)
            send_frame(4'($urandom), op, 1'($urandom), $urandom_range(0, 8), LEN_SHORT);
        else if (r < 73)
            send_frame(4'($urandom), op, 1'($urandom), $urandom_range(9, 60), LEN_SHORT);
        else if (r < 75)
            send_frame(4'($urandom), op, 1'($urandom), 125, LEN_SHORT);
        else if (r < 86)
            send_frame(4'($urandom), op, 1'($urandom), $urandom_range(0, 40), LEN_EXT16);
        else if (r < 88)
            send_frame(4'($urandom), op, 1'($urandom), $urandom_range(256, 300), LEN_EXT16);
        else
            send_frame(4'($urandom), op, 1'($urandom), $urandom_range(0, 24), LEN_EXT64);
    endtask

    initial
    begin
        int r;
        rst_n    <= 1'b0;
        rx_valid <= 1'b0;
        rx_byte  <= 8'h00;
        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        send_frame(4'h8, OP_TEXT, 1'b0, 0, LEN_SHORT);
        // unknown opcode with every header bit set, one zero payload byte
        push_stream_byte({4'hF, OP_RESERVED});
        push_stream_byte(8'h01);
        push_stream_byte(8'h00);
        send_frame(4'h0, OP_PONG, 1'b1, 0, LEN_SHORT);
        send_frame(4'h4, OP_BINARY, 1'b0, 1, LEN_EXT16);
        send_frame(4'h8, OP_TEXT, 1'b1, 4, LEN_SHORT);

        while (bytes_sent < STREAM_BYTES)
            send_random_frame();

        // close ends the stream for good, the trailing bytes must be swallowed
        r = $urandom_range(0, 99);
        if (r < 40)
            send_frame(4'($urandom), OP_CLOSE, 1'($urandom), 0, LEN_SHORT);
        else if (r < 80)
            send_frame(4'($urandom), OP_CLOSE, 1'($urandom), $urandom_range(1, 6), LEN_SHORT);
        else
            send_frame(4'($urandom), OP_CLOSE, 1'($urandom), $urandom_range(0, 5), LEN_EXT16);
        repeat ($urandom_range(4, 12)) push_stream_byte(8'($urandom));
        rx_valid <= 1'b0;

        while (words_due != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (mismatches == 0 && words_due == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

    initial
    begin
        int  hold;
        bit  stalled;
        hold    = 0;
        stalled = 1'b0;
        res_stall <= 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold > 0)
                hold--;
            else if (stalled)
            begin
                stalled = 1'b0;
                hold = ($urandom_range(0, 99) < 5) ? $urandom_range(60, 200)
                                                   : $urandom_range(0, 10);
            end
            else
            begin
                hold = idle_span();
                stalled = (hold > 0);
                if (hold > 0)
                    hold--;
            end
            res_stall <= stalled;
        end
    end

    initial
    begin
        int idle_cycles;
        idle_cycles = 0;
        while (idle_cycles < IDLE_LIMIT)
        begin
            @(posedge clk);
            if ((rx_valid && !rx_stall) || (res_valid && !res_stall))
                idle_cycles = 0;
            else
                idle_cycles++;
        end
        $display("simulation failed");
        $finish;
    end

endmodule
